// ===== rtl/core/segment_box_intersect_assert.svh =====
// ----------------------------------------------------------------------------
// segment_box_intersect_assert.svh
// Assertion macros used by sbi_checker, the segment/box intersection port checker.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_BOX_INTERSECT_ASSERT_SVH
`define SEGMENT_BOX_INTERSECT_ASSERT_SVH

// Same-cycle implication, masked while in reset.
`define SBI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segment_box_intersect check failed");

// Next-cycle implication, masked while in reset.
`define SBI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segment_box_intersect check failed");

// Next-cycle implication that also holds through reset.
`define SBI_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("segment_box_intersect check failed");

`endif

// ===== rtl/core/sbi_pkg.sv =====
// ----------------------------------------------------------------------------
// sbi_pkg
// Shared types and constants for the segment/box intersection pipeline.
// ----------------------------------------------------------------------------
package sbi_pkg;

  // Position of a coordinate relative to the box span on one axis.
  typedef enum logic [1:0] {
    BAND_LOW,
    BAND_MID,
    BAND_HIGH
  } sbi_band_t;

  // Decision already settled by the region codes.
  typedef struct packed {
    logic hit;
    logic miss;
  } sbi_early_t;

  // Payload load strobes for the product and sign stages.
  typedef struct packed {
    logic ld2;
    logic ld3;
  } sbi_adv_t;

  localparam int NUM_CORNERS = 4;

  // Two bands are opposite when they sit on opposite sides (or both in the middle).
  function automatic logic opposite(input sbi_band_t a, input sbi_band_t b);
    return ((a == BAND_LOW) && (b == BAND_HIGH)) ||
           ((a == BAND_HIGH) && (b == BAND_LOW)) ||
           ((a == BAND_MID) && (b == BAND_MID));
  endfunction

endpackage

// ===== rtl/core/sbi_region.sv =====
// ----------------------------------------------------------------------------
// sbi_region
// Stage 1: region codes of both endpoints, early decision and the coordinate
// differences that feed the cross products.
// ----------------------------------------------------------------------------
module sbi_region #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          ld,
  input  logic signed [COORD_BITS-1:0]  box_min_x,
  input  logic signed [COORD_BITS-1:0]  box_min_y,
  input  logic signed [COORD_BITS-1:0]  box_max_x,
  input  logic signed [COORD_BITS-1:0]  box_max_y,
  input  logic signed [COORD_BITS-1:0]  seg_start_x,
  input  logic signed [COORD_BITS-1:0]  seg_start_y,
  input  logic signed [COORD_BITS-1:0]  seg_end_x,
  input  logic signed [COORD_BITS-1:0]  seg_end_y,
  output sbi_pkg::sbi_early_t           early_r,
  output logic signed [COORD_BITS:0]    dx_r,
  output logic signed [COORD_BITS:0]    dy_r,
  output logic signed [COORD_BITS:0]    cx_lo_r,
  output logic signed [COORD_BITS:0]    cx_hi_r,
  output logic signed [COORD_BITS:0]    cy_lo_r,
  output logic signed [COORD_BITS:0]    cy_hi_r
);
  import sbi_pkg::*;

  localparam int DW = COORD_BITS + 1;

  function automatic sbi_band_t classify(input logic signed [COORD_BITS-1:0] lo,
                                         input logic signed [COORD_BITS-1:0] hi,
                                         input logic signed [COORD_BITS-1:0] p);
    sbi_band_t b;
    b = BAND_MID;
    if (hi < p) begin
      b = BAND_HIGH;
    end else if (p < lo) begin
      b = BAND_LOW;
    end
    return b;
  endfunction

  function automatic logic signed [DW-1:0] diff(input logic signed [COORD_BITS-1:0] a,
                                                input logic signed [COORD_BITS-1:0] b);
    return {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
  endfunction

  sbi_band_t  col0, row0, col1, row1;
  sbi_early_t early_nxt;

  always_comb begin
    col0 = classify(box_min_x, box_max_x, seg_start_x);
    row0 = classify(box_min_y, box_max_y, seg_start_y);
    col1 = classify(box_min_x, box_max_x, seg_end_x);
    row1 = classify(box_min_y, box_max_y, seg_end_y);
    early_nxt.hit  = ((row0 == BAND_MID) && (col0 == BAND_MID)) ||
                     ((row1 == BAND_MID) && (col1 == BAND_MID)) ||
                     (opposite(row0, row1) && opposite(col0, col1));
    early_nxt.miss = (row0 == row1) || (col0 == col1);
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      early_r <= early_nxt;
      dx_r    <= diff(seg_end_x, seg_start_x);
      dy_r    <= diff(seg_end_y, seg_start_y);
      cx_lo_r <= diff(box_min_x, seg_start_x);
      cx_hi_r <= diff(box_max_x, seg_start_x);
      cy_lo_r <= diff(box_min_y, seg_start_y);
      cy_hi_r <= diff(box_max_y, seg_start_y);
    end
  end

endmodule

// ===== rtl/core/sbi_cross.sv =====
// ----------------------------------------------------------------------------
// sbi_cross
// Stages 2 and 3: the four distinct products, then the exact sign of the
// cross product for each box corner.
// ----------------------------------------------------------------------------
module sbi_cross #(
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  sbi_pkg::sbi_adv_t                     adv,
  input  sbi_pkg::sbi_early_t                   early_in,
  input  logic signed [COORD_BITS:0]            dx,
  input  logic signed [COORD_BITS:0]            dy,
  input  logic signed [COORD_BITS:0]            cx_lo,
  input  logic signed [COORD_BITS:0]            cx_hi,
  input  logic signed [COORD_BITS:0]            cy_lo,
  input  logic signed [COORD_BITS:0]            cy_hi,
  output sbi_pkg::sbi_early_t                   early_r,
  output logic [sbi_pkg::NUM_CORNERS-1:0]       neg_r,
  output logic [sbi_pkg::NUM_CORNERS-1:0]       zero_r
);
  import sbi_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;

  sbi_early_t             early_p_r;
  logic signed [PW-1:0]   dx_cylo_r, dx_cyhi_r, dy_cxlo_r, dy_cxhi_r;
  logic signed [XW-1:0]   cprod [NUM_CORNERS];
  logic [NUM_CORNERS-1:0] neg_nxt, zero_nxt;

  function automatic logic signed [XW-1:0] sub(input logic signed [PW-1:0] p,
                                               input logic signed [PW-1:0] q);
    return {p[PW-1], p} - {q[PW-1], q};
  endfunction

  always_ff @(posedge clk) begin
    if (adv.ld2) begin
      early_p_r <= early_in;
      dx_cylo_r <= PW'(dx * cy_lo);
      dx_cyhi_r <= PW'(dx * cy_hi);
      dy_cxlo_r <= PW'(dy * cx_lo);
      dy_cxhi_r <= PW'(dy * cx_hi);
    end
  end

  // Corner order: (min,min), (max,min), (min,max), (max,max).
  always_comb begin
    cprod[0] = sub(dx_cylo_r, dy_cxlo_r);
    cprod[1] = sub(dx_cylo_r, dy_cxhi_r);
    cprod[2] = sub(dx_cyhi_r, dy_cxlo_r);
    cprod[3] = sub(dx_cyhi_r, dy_cxhi_r);
    for (int i = 0; i < NUM_CORNERS; i++) begin
      neg_nxt[i]  = cprod[i][XW-1];
      zero_nxt[i] = (cprod[i] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.ld3) begin
      early_r <= early_p_r;
      neg_r   <= neg_nxt;
      zero_r  <= zero_nxt;
    end
  end

endmodule

// ===== rtl/core/segment_box_intersect.sv =====
// ----------------------------------------------------------------------------
// segment_box_intersect
// Segment versus axis-aligned box hit test, fully pipelined.
// ----------------------------------------------------------------------------
// One test per cycle while the output is not stalled. An accepted input
// transaction passes through the four register stages in order: region codes
// and differences, the signed products, the cross-product signs, and the
// output register. A stall on the output only backs up the pipeline as far as
// it is full; empty stages keep accepting.
module segment_box_intersect #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  in_box_min_x,
  input  logic signed [COORD_BITS-1:0]  in_box_min_y,
  input  logic signed [COORD_BITS-1:0]  in_box_max_x,
  input  logic signed [COORD_BITS-1:0]  in_box_max_y,
  input  logic signed [COORD_BITS-1:0]  in_seg_start_x,
  input  logic signed [COORD_BITS-1:0]  in_seg_start_y,
  input  logic signed [COORD_BITS-1:0]  in_seg_end_x,
  input  logic signed [COORD_BITS-1:0]  in_seg_end_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit
);
  import sbi_pkg::*;

  logic       v1_r, v2_r, v3_r, out_valid_r;
  logic       v1_nxt, v2_nxt, v3_nxt, out_valid_nxt;
  logic       rdy1, rdy2, rdy3, rdy4;
  logic       ld1;
  sbi_adv_t   adv;
  sbi_early_t early1, early3;
  logic signed [COORD_BITS:0] dx, dy, cx_lo, cx_hi, cy_lo, cy_hi;
  logic [NUM_CORNERS-1:0] neg, zero;
  logic       pos0, any_neg, any_pos, hit_nxt, out_hit_r;

  // A stage can take new data when empty or when its contents move on.
  always_comb begin
    rdy4    = !out_valid_r || !out_stall;
    rdy3    = !v3_r || rdy4;
    rdy2    = !v2_r || rdy3;
    rdy1    = !v1_r || rdy2;
    ld1     = in_valid && rdy1;
    adv.ld2 = v1_r && rdy2;
    adv.ld3 = v2_r && rdy3;
    v1_nxt        = rdy1 ? in_valid : v1_r;
    v2_nxt        = rdy2 ? v1_r : v2_r;
    v3_nxt        = rdy3 ? v2_r : v3_r;
    out_valid_nxt = rdy4 ? v3_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  sbi_region #(.COORD_BITS(COORD_BITS)) u_region (
    .clk         (clk),
    .ld          (ld1),
    .box_min_x   (in_box_min_x),
    .box_min_y   (in_box_min_y),
    .box_max_x   (in_box_max_x),
    .box_max_y   (in_box_max_y),
    .seg_start_x (in_seg_start_x),
    .seg_start_y (in_seg_start_y),
    .seg_end_x   (in_seg_end_x),
    .seg_end_y   (in_seg_end_y),
    .early_r     (early1),
    .dx_r        (dx),
    .dy_r        (dy),
    .cx_lo_r     (cx_lo),
    .cx_hi_r     (cx_hi),
    .cy_lo_r     (cy_lo),
    .cy_hi_r     (cy_hi)
  );

  sbi_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk      (clk),
    .adv      (adv),
    .early_in (early1),
    .dx       (dx),
    .dy       (dy),
    .cx_lo    (cx_lo),
    .cx_hi    (cx_hi),
    .cy_lo    (cy_lo),
    .cy_hi    (cy_hi),
    .early_r  (early3),
    .neg_r    (neg),
    .zero_r   (zero)
  );

  // Hit on an early hit, or, with no early miss, when some other corner lies strictly opposite corner 0.
  always_comb begin
    pos0    = !neg[0] && !zero[0];
    any_neg = |neg[NUM_CORNERS-1:1];
    any_pos = |(~neg[NUM_CORNERS-1:1] & ~zero[NUM_CORNERS-1:1]);
    hit_nxt = early3.hit ||
              (!early3.miss && ((pos0 && any_neg) || (neg[0] && any_pos)));
  end

  always_ff @(posedge clk) begin
    if (v3_r && rdy4) begin
      out_hit_r <= hit_nxt;
    end
  end

  assign in_stall  = !rdy1;
  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

endmodule

// ===== rtl/core/sbi_checker.sv =====
// ----------------------------------------------------------------------------
// sbi_checker
// Port-level checks for segment_box_intersect, bound to the top level.
// ----------------------------------------------------------------------------
`include "segment_box_intersect_assert.svh"

module sbi_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic signed [COORD_BITS-1:0]  in_box_min_x,
  input logic signed [COORD_BITS-1:0]  in_box_min_y,
  input logic signed [COORD_BITS-1:0]  in_box_max_x,
  input logic signed [COORD_BITS-1:0]  in_box_max_y,
  input logic signed [COORD_BITS-1:0]  in_seg_start_x,
  input logic signed [COORD_BITS-1:0]  in_seg_start_y,
  input logic signed [COORD_BITS-1:0]  in_seg_end_x,
  input logic signed [COORD_BITS-1:0]  in_seg_end_y,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_hit
);

  logic in_acc, start_inside, both_left;

  assign in_acc       = in_valid && !in_stall;
  assign start_inside = (in_seg_start_x >= in_box_min_x) && (in_seg_start_x <= in_box_max_x) &&
                        (in_seg_start_y >= in_box_min_y) && (in_seg_start_y <= in_box_max_y);
  // only on a box that is not inverted in x
  assign both_left    = (in_box_min_x <= in_box_max_x) &&
                        (in_seg_start_x < in_box_min_x) && (in_seg_end_x < in_box_min_x);

  // A stalled result holds its value.
  `SBI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_hit))

  // With nothing waiting at the output the pipeline can always take a transaction.
  `SBI_ASSERT_NOW(a_no_false_stall, !out_valid, !in_stall)

  // Reset empties the pipeline.
  `SBI_ASSERT_ALWAYS(a_reset_empty, !rst_n, !out_valid)

  // Start point inside the box: the result is a hit if the output does not stall meanwhile.
  `SBI_ASSERT_NEXT(a_inside_hit, in_acc && start_inside ##1 !out_stall ##1 !out_stall ##1 !out_stall, out_valid && out_hit)

  // Both endpoints left of the box: the result is a miss if the output does not stall meanwhile.
  `SBI_ASSERT_NEXT(a_left_miss, in_acc && both_left ##1 !out_stall ##1 !out_stall ##1 !out_stall, out_valid && !out_hit)

endmodule

bind segment_box_intersect sbi_checker #(.COORD_BITS(COORD_BITS)) u_sbi_checker (.*);

// ===== tb/segment_box_intersect_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_box_intersect_checker
// Watches both channels of the segment/box hit test, predicts the hit flag
// of every accepted test and compares it with the result that comes out.
// ----------------------------------------------------------------------------
module segment_box_intersect_checker #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_box_min_x,
  input  logic signed [COORD_BITS-1:0] in_box_min_y,
  input  logic signed [COORD_BITS-1:0] in_box_max_x,
  input  logic signed [COORD_BITS-1:0] in_box_max_y,
  input  logic signed [COORD_BITS-1:0] in_seg_start_x,
  input  logic signed [COORD_BITS-1:0] in_seg_start_y,
  input  logic signed [COORD_BITS-1:0] in_seg_end_x,
  input  logic signed [COORD_BITS-1:0] in_seg_end_y,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         out_hit,
  output int                           errors,
  output int                           pending
);
  import sbi_pkg::*;

  typedef struct packed {
    logic        hit;
    logic [31:0] test_idx;
  } hit_expect_t;

  hit_expect_t hit_expect_q[$];
  hit_expect_t head;
  int unsigned test_count;

  // Band of one coordinate against the box span; the upper side wins on an
  // inverted box.
  function automatic sbi_band_t band_of(longint p, longint lo, longint hi);
    if (hi < p) return BAND_HIGH;
    if (p < lo) return BAND_LOW;
    return BAND_MID;
  endfunction

  function automatic int band_offset(sbi_band_t b);
    case (b)
      BAND_LOW:  return -1;
      BAND_HIGH: return 1;
      default:   return 0;
    endcase
  endfunction

  // Sign of a*b - c*d; operands stay below 2^17, so 64 bits are exact.
  function automatic int cross_sign(longint a, longint b, longint c, longint d);
    longint r;
    r = a * b - c * d;
    return (r > 0) ? 1 : ((r < 0) ? -1 : 0);
  endfunction

  function automatic logic segment_hits(
    longint lx, longint ly, longint hx, longint hy,
    longint sx, longint sy, longint ex, longint ey
  );
    int     ox0, oy0, ox1, oy1;
    int     s0, si;
    longint dx, dy;
    longint cx[4];
    longint cy[4];
    logic   hit;
    ox0 = band_offset(band_of(sx, lx, hx));
    oy0 = band_offset(band_of(sy, ly, hy));
    ox1 = band_offset(band_of(ex, lx, hx));
    oy1 = band_offset(band_of(ey, ly, hy));
    if ((ox0 == 0 && oy0 == 0) || (ox1 == 0 && oy1 == 0)) return 1'b1;
    // endpoints in mirrored regions across the box
    if (ox0 + ox1 == 0 && oy0 + oy1 == 0) return 1'b1;
    if (ox0 == ox1 || oy0 == oy1) return 1'b0;
    dx = ex - sx;
    dy = ey - sy;
    cx[0] = lx - sx; cy[0] = ly - sy;
    cx[1] = hx - sx; cy[1] = ly - sy;
    cx[2] = lx - sx; cy[2] = hy - sy;
    cx[3] = hx - sx; cy[3] = hy - sy;
    s0 = cross_sign(dx, cy[0], dy, cx[0]);
    hit = 1'b0;
    for (int i = 1; i < NUM_CORNERS; i++) begin
      si = cross_sign(dx, cy[i], dy, cx[i]);
      if ((s0 > 0 && si < 0) || (s0 < 0 && si > 0)) hit = 1'b1;
    end
    return hit;
  endfunction

  initial begin
    errors     = 0;
    pending    = 0;
    test_count = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hit_expect_q.delete();
      pending = 0;
    end else begin
      if (in_valid && !in_stall) begin
        head.hit = segment_hits(in_box_min_x, in_box_min_y, in_box_max_x, in_box_max_y,
                                in_seg_start_x, in_seg_start_y, in_seg_end_x, in_seg_end_y);
        head.test_idx = test_count;
        hit_expect_q.push_back(head);
        test_count++;
      end
      if (out_valid && !out_stall) begin
        if (hit_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transaction: expected none, actual hit=%0b",
                   $time, out_hit);
        end else begin
          head = hit_expect_q.pop_front();
          if (out_hit !== head.hit) begin
            errors++;
            $display("%0t: test %0d hit mismatch: expected %0b, actual %0b",
                     $time, head.test_idx, head.hit, out_hit);
          end
        end
      end
      pending = hit_expect_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives segment/box hit tests into the pipeline with random gaps and output
// stalls: a directed set of corner cases, then random boxes and segments
// biased toward the cross-product decision. The checker scores every result.
// ----------------------------------------------------------------------------
module testbench;
  import sbi_pkg::*;

  localparam int COORD_BITS  = 16;
  localparam int NUM_RANDOM  = 1700;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 120;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic signed [COORD_BITS-1:0] in_box_min_x;
  logic signed [COORD_BITS-1:0] in_box_min_y;
  logic signed [COORD_BITS-1:0] in_box_max_x;
  logic signed [COORD_BITS-1:0] in_box_max_y;
  logic signed [COORD_BITS-1:0] in_seg_start_x;
  logic signed [COORD_BITS-1:0] in_seg_start_y;
  logic signed [COORD_BITS-1:0] in_seg_end_x;
  logic signed [COORD_BITS-1:0] in_seg_end_y;
  logic                         out_valid;
  logic                         out_stall;
  logic                         out_hit;

  int          errors;
  int          pending;
  int unsigned sent_count;
  int unsigned cycle_count = 0;
  bit          long_hold_req;

  segment_box_intersect #(.COORD_BITS(COORD_BITS)) dut (.*);

  segment_box_intersect_checker #(.COORD_BITS(COORD_BITS)) hit_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int clamp_coord(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Coordinate inside the given band of the span [lo, hi], often near its edge.
  function automatic int coord_in_band(sbi_band_t b, int lo, int hi);
    int a, z, reach;
    a = (lo < hi) ? lo : hi;
    z = (lo < hi) ? hi : lo;
    reach = ($urandom_range(0, 1) == 0) ? (z - a) + 64 : 65535;
    if ($urandom_range(0, 9) == 0) begin
      case (b)
        BAND_LOW:  return clamp_coord(lo - 1);
        BAND_HIGH: return clamp_coord(hi + 1);
        default:   return ($urandom_range(0, 1) == 0) ? lo : hi;
      endcase
    end
    case (b)
      BAND_LOW:  return clamp_coord(lo - 1 - int'($urandom_range(0, reach)));
      BAND_HIGH: return clamp_coord(hi + 1 + int'($urandom_range(0, reach)));
      default:   return a + int'($urandom_range(0, z - a));
    endcase
  endfunction

  task automatic send_test(int lx, int ly, int hx, int hy, int sx, int sy, int ex, int ey);
    int gap;
    // every third block of 64 tests goes back to back
    gap = (((sent_count / 64) % 3) == 0) ? 0 : int'($urandom_range(0, 18));
    if (sent_count == 400 || sent_count == 1200) long_hold_req = 1'b1;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_box_min_x   = lx[COORD_BITS-1:0];
    in_box_min_y   = ly[COORD_BITS-1:0];
    in_box_max_x   = hx[COORD_BITS-1:0];
    in_box_max_y   = hy[COORD_BITS-1:0];
    in_seg_start_x = sx[COORD_BITS-1:0];
    in_seg_start_y = sy[COORD_BITS-1:0];
    in_seg_end_x   = ex[COORD_BITS-1:0];
    in_seg_end_y   = ey[COORD_BITS-1:0];
    in_valid       = 1'b1;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  task automatic random_test();
    int        kind, lx, ly, hx, hy, t;
    sbi_band_t b[4];
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      send_test($urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom);
    end else begin
      lx = int'($urandom_range(0, 60000)) - 32768;
      ly = int'($urandom_range(0, 60000)) - 32768;
      hx = clamp_coord(lx + int'($urandom_range(0, (kind < 5) ? 200 : 20000)));
      hy = clamp_coord(ly + int'($urandom_range(0, (kind < 5) ? 200 : 20000)));
      if ($urandom_range(0, 19) == 0) begin
        t = lx; lx = hx; hx = t;
      end
      if ($urandom_range(0, 19) == 0) begin
        t = ly; ly = hy; hy = t;
      end
      // b holds x0, y0, x1, y1; most tests need the cross-product decision
      do begin
        for (int k = 0; k < 4; k++) b[k] = sbi_band_t'($urandom_range(0, 2));
      end while (kind >= 4 &&
                 !(b[0] != b[2] && b[1] != b[3] &&
                   !(b[0] == BAND_MID && b[1] == BAND_MID) &&
                   !(b[2] == BAND_MID && b[3] == BAND_MID) &&
                   !(b[0] != BAND_MID && b[2] != BAND_MID &&
                     b[1] != BAND_MID && b[3] != BAND_MID)));
      send_test(lx, ly, hx, hy,
                coord_in_band(b[0], lx, hx), coord_in_band(b[1], ly, hy),
                coord_in_band(b[2], lx, hx), coord_in_band(b[3], ly, hy));
    end
  endtask

  // Result side: random stalls per result, calm stretches, and long hold-offs
  // requested by the sender so the pipeline fills and stalls its input.
  initial begin
    int n, taken;
    out_stall = 1'b0;
    taken     = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        n = LONG_HOLD;
      end else if (((taken / 50) % 4) == 1) begin
        n = 0;
      end else begin
        n = $urandom_range(0, 18);
      end
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_box_min_x   = '0;
    in_box_min_y   = '0;
    in_box_max_x   = '0;
    in_box_max_y   = '0;
    in_seg_start_x = '0;
    in_seg_start_y = '0;
    in_seg_end_x   = '0;
    in_seg_end_y   = '0;
    sent_count     = 0;
    long_hold_req  = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // field extremes
    send_test(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_test(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_test(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    // an endpoint inside
    send_test(-100, -100, 100, 100, 0, 0, 500, 500);
    send_test(-100, -100, 100, 100, 500, -500, 0, 0);
    send_test(-100, -100, 100, 100, 0, 0, 0, 0);
    // mirrored regions
    send_test(-100, -100, 100, 100, -500, 0, 500, 0);
    send_test(-100, -100, 100, 100, -500, -500, 500, 500);
    send_test(-100, -100, 100, 100, -100, -500, -100, 500);
    // shared row, shared column, zero-length outside
    send_test(-100, -100, 100, 100, -500, 500, 500, 500);
    send_test(-100, -100, 100, 100, 500, -500, 500, 500);
    send_test(-100, -100, 100, 100, 500, 500, 500, 500);
    // cross-product decision: cut corner, clear miss, just inside the edge
    send_test(-100, -100, 100, 100, -150, 0, 0, 150);
    send_test(-100, -100, 100, 100, -500, 0, 0, 500);
    send_test(-100, -100, 100, 100, 101, 0, 0, 101);
    // line through corner 0, line grazing corner 3
    send_test(-100, -100, 100, 100, -200, 0, 0, -200);
    send_test(-100, -100, 100, 100, 0, 200, 200, 0);
    // inverted box
    send_test(100, 100, -100, -100, 0, -500, 0, 500);
    send_test(100, 100, -100, -100, -500, 0, 0, 500);
    // point box
    send_test(0, 0, 0, 0, -10, -10, 10, 10);
    send_test(0, 0, 0, 0, -10, 0, 0, 10);
    // products beyond 32 bits
    send_test(30000, -32768, 32767, -30000, -32768, -31000, 31000, 32767);
    send_test(-32768, -32768, -30000, -30000, -32768, 32767, 32767, -32768);

    repeat (NUM_RANDOM) random_test();
    @(negedge clk);
    in_valid = 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (12) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sbi_pkg.sv
rtl/core/sbi_region.sv
rtl/core/sbi_cross.sv
rtl/core/segment_box_intersect.sv
rtl/core/sbi_checker.sv
tb/segment_box_intersect_checker.sv
tb/testbench.sv
